[src/fcop_pkg.sv]
// Shared types and constants of the force plate centre-of-pressure core.
// Used by the top level; no dependencies of its own.
package fcop_pkg;

  // Configuration register indexes on the write port
  typedef enum logic [2:0] {
    REG_ARM_X        = 3'd0,
    REG_ARM_Y        = 3'd1,
    REG_PLATE_HEIGHT = 3'd2,
    REG_CENTER_X     = 3'd3,
    REG_CENTER_Y     = 3'd4,
    REG_FZ_THRESHOLD = 3'd5
  } reg_index_t;

  localparam logic [9:0]  ARM_X_RESET        = 10'd210;
  localparam logic [9:0]  ARM_Y_RESET        = 10'd350;
  localparam logic [9:0]  PLATE_HEIGHT_RESET = 10'd75;
  localparam logic [17:0] FZ_THRESHOLD_RESET = 18'd0;

  localparam logic signed [23:0] COP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COP_MIN = -24'sh800000;

  // Force and moment fields at their result widths
  typedef struct packed {
    logic signed [16:0] fx;
    logic signed [17:0] fy;
    logic signed [18:0] fz;
    logic signed [27:0] mx;
    logic signed [27:0] my;
    logic signed [28:0] mz;
  } res_fields_t;

  // What rides alongside the division pipeline
  typedef struct packed {
    logic        ok;
    logic        neg_x;
    logic        neg_y;
    res_fields_t f;
  } side_t;

endpackage

[src/fcop_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Unsigned operands; one division per cycle.
module fcop_div #(
  parameter int NUM_BITS = 30,
  parameter int DEN_BITS = 18
) (
  input  logic                clk,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [NUM_BITS-1:0] quo
);

  logic [DEN_BITS-1:0] rem_q [NUM_BITS];
  logic [NUM_BITS-1:0] quo_q [NUM_BITS];
  logic [NUM_BITS-1:0] num_q [NUM_BITS-1];
  logic [DEN_BITS-1:0] den_q [NUM_BITS-1];

  for (genvar i = 0; i < NUM_BITS; i++) begin : g_stage
    logic [DEN_BITS-1:0] rem_in;
    logic [DEN_BITS-1:0] den_in;
    logic [NUM_BITS-1:0] num_in;
    logic [NUM_BITS-1:0] quo_in;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign num_in = num_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    always_comb begin
      trial = {rem_in, num_in[NUM_BITS-1]};
      diff  = trial - {1'b0, den_in};
      ge    = trial >= {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      rem_q[i] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo_q[i] <= {quo_in[NUM_BITS-2:0], ge};
    end

    // Operands move on only while a later stage still needs them
    if (i < NUM_BITS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        num_q[i] <= {num_in[NUM_BITS-2:0], 1'b0};
        den_q[i] <= den_in;
      end
    end
  end

  assign quo = quo_q[NUM_BITS-1];

endmodule

[src/force_plate_cop_calculator_core.sv]
// Force plate centre-of-pressure core: forces, moments and COP per sample.
// Depends on fcop_pkg and fcop_div.
// done follows an accepted sample through stages 1 to 4, the divider, stage 5
// and the output register; one sample is taken every cycle, busy stays low.
// The divider is a restoring one, SAMPLE_BITS+14 stages of one bit.
// Reset (synchronous) drops samples in flight and restores register defaults;
// results are strobed by done for one cycle and the receiver cannot stall.
module force_plate_cop_calculator_core
  import fcop_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] ch_x12,
  input  logic signed [SAMPLE_BITS-1:0] ch_x34,
  input  logic signed [SAMPLE_BITS-1:0] ch_y14,
  input  logic signed [SAMPLE_BITS-1:0] ch_y23,
  input  logic signed [SAMPLE_BITS-1:0] ch_z1,
  input  logic signed [SAMPLE_BITS-1:0] ch_z2,
  input  logic signed [SAMPLE_BITS-1:0] ch_z3,
  input  logic signed [SAMPLE_BITS-1:0] ch_z4,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [17:0]                   cfg_wdata,
  output logic                          done,
  output logic                          cop_valid,
  output logic signed [23:0]            cop_x,
  output logic signed [23:0]            cop_y,
  output logic signed [16:0]            force_x,
  output logic signed [17:0]            force_y,
  output logic signed [18:0]            force_z,
  output logic signed [27:0]            moment_x,
  output logic signed [27:0]            moment_y,
  output logic signed [28:0]            moment_z
);

  localparam int XW  = SAMPLE_BITS + 1;   // fx, x and y differences
  localparam int YW  = SAMPLE_BITS + 2;   // fy, z differences
  localparam int ZW  = SAMPLE_BITS + 3;   // fz
  localparam int PW  = SAMPLE_BITS + 13;  // products and moments
  localparam int NW  = SAMPLE_BITS + 14;  // numerators and quotient
  localparam int DW  = SAMPLE_BITS + 2;   // divisor (fz when positive)
  localparam int SW  = NW + 2;            // centre plus offset
  localparam int CW  = ((ZW > 18) ? ZW : 18) + 1;
  localparam int LAT = NW + 6;

  // ---------------- configuration registers ----------------
  logic [9:0]         arm_x;
  logic [9:0]         arm_y;
  logic [9:0]         plate_height;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [17:0]        fz_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_x        <= ARM_X_RESET;
      arm_y        <= ARM_Y_RESET;
      plate_height <= PLATE_HEIGHT_RESET;
      center_x     <= '0;
      center_y     <= '0;
      fz_threshold <= FZ_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ARM_X:        arm_x        <= cfg_wdata[9:0];
        REG_ARM_Y:        arm_y        <= cfg_wdata[9:0];
        REG_PLATE_HEIGHT: plate_height <= cfg_wdata[9:0];
        REG_CENTER_X:     center_x     <= cfg_wdata[15:0];
        REG_CENTER_Y:     center_y     <= cfg_wdata[15:0];
        REG_FZ_THRESHOLD: fz_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [10:0] ex_s;
  logic signed [10:0] ey_s;
  logic signed [10:0] ez_s;

  assign ex_s = $signed({1'b0, arm_x});
  assign ey_s = $signed({1'b0, arm_y});
  assign ez_s = $signed({1'b0, plate_height});

  // The pipeline never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: channel sums and differences ----------------
  logic signed [ZW-1:0] x12_e, x34_e, y14_e, y23_e, z1_e, z2_e, z3_e, z4_e;
  logic signed [ZW-1:0] t_fx, t_fy, t_fz, t_zdx, t_zdy, t_xd, t_yd;

  always_comb begin
    x12_e = ZW'(ch_x12);
    x34_e = ZW'(ch_x34);
    y14_e = ZW'(ch_y14);
    y23_e = ZW'(ch_y23);
    z1_e  = ZW'(ch_z1);
    z2_e  = ZW'(ch_z2);
    z3_e  = ZW'(ch_z3);
    z4_e  = ZW'(ch_z4);
    t_fx  = x12_e + x34_e;
    t_fy  = -(y14_e + y23_e);
    t_fz  = -(z1_e + z2_e + z3_e + z4_e);
    t_zdx = z3_e + z4_e - z1_e - z2_e;
    t_zdy = z1_e + z4_e - z2_e - z3_e;
    t_xd  = x34_e - x12_e;
    t_yd  = y14_e - y23_e;
  end

  logic                 vld1;
  logic signed [XW-1:0] s1_fx, s1_xd, s1_yd;
  logic signed [YW-1:0] s1_fy, s1_zdx, s1_zdy;
  logic signed [ZW-1:0] s1_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_fx  <= t_fx[XW-1:0];
    s1_fy  <= t_fy[YW-1:0];
    s1_fz  <= t_fz;
    s1_zdx <= t_zdx[YW-1:0];
    s1_zdy <= t_zdy[YW-1:0];
    s1_xd  <= t_xd[XW-1:0];
    s1_yd  <= t_yd[XW-1:0];
  end

  // ---------------- stage 2: products ----------------
  logic                   vld2;
  logic signed [XW-1:0]   s2_fx;
  logic signed [YW-1:0]   s2_fy;
  logic signed [ZW-1:0]   s2_fz;
  logic signed [PW-1:0]   s2_mx, s2_my, s2_py;
  logic signed [PW-2:0]   s2_mza, s2_mzb, s2_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    s2_fx  <= s1_fx;
    s2_fy  <= s1_fy;
    s2_fz  <= s1_fz;
    s2_mx  <= PW'(s1_zdx) * PW'(ey_s);
    s2_my  <= PW'(s1_zdy) * PW'(ex_s);
    s2_mza <= (PW-1)'(s1_xd) * (PW-1)'(ey_s);
    s2_mzb <= (PW-1)'(s1_yd) * (PW-1)'(ex_s);
    s2_px  <= (PW-1)'(s1_fx) * (PW-1)'(ez_s);
    s2_py  <= PW'(s1_fy) * PW'(ez_s);
  end

  // ---------------- stage 3: numerators, threshold ----------------
  logic signed [CW-1:0] fz_cmp;
  logic signed [CW-1:0] thr_cmp;
  logic signed [PW-1:0] mz_sum;

  always_comb begin
    fz_cmp  = CW'(s2_fz);
    thr_cmp = $signed({{(CW-18){1'b0}}, fz_threshold});
    mz_sum  = PW'(s2_mza) + PW'(s2_mzb);
  end

  logic                 vld3;
  logic                 s3_ok;
  logic signed [NW-1:0] s3_nx, s3_ny;
  logic signed [ZW-1:0] s3_fz;
  res_fields_t          s3_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    s3_ok   <= fz_cmp > thr_cmp;
    s3_nx   <= NW'(s2_px) - NW'(s2_my);
    s3_ny   <= NW'(s2_py) - NW'(s2_mx);
    s3_fz   <= s2_fz;
    s3_f.fx <= 17'(s2_fx);
    s3_f.fy <= 18'(s2_fy);
    s3_f.fz <= 19'(s2_fz);
    s3_f.mx <= 28'(s2_mx);
    s3_f.my <= 28'(s2_my);
    s3_f.mz <= 29'(mz_sum);
  end

  // ---------------- stage 4: magnitudes for the divider ----------------
  logic          vld4;
  side_t         side4;
  logic [NW-1:0] s4_nx_mag, s4_ny_mag;
  logic [DW-1:0] s4_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    s4_nx_mag   <= s3_nx[NW-1] ? -s3_nx : s3_nx;
    s4_ny_mag   <= s3_ny[NW-1] ? -s3_ny : s3_ny;
    s4_den      <= s3_fz[DW-1:0];
    side4.ok    <= s3_ok;
    side4.neg_x <= s3_nx[NW-1];
    side4.neg_y <= s3_ny[NW-1];
    side4.f     <= s3_f;
  end

  // ---------------- divider stages ----------------
  logic [NW-1:0] quo_x, quo_y;

  fcop_div #(
    .NUM_BITS (NW),
    .DEN_BITS (DW)
  ) u_div_x (
    .clk (clk),
    .num (s4_nx_mag),
    .den (s4_den),
    .quo (quo_x)
  );

  fcop_div #(
    .NUM_BITS (NW),
    .DEN_BITS (DW)
  ) u_div_y (
    .clk (clk),
    .num (s4_ny_mag),
    .den (s4_den),
    .quo (quo_y)
  );

  // Sideband delay line, aligned with the divider stages
  logic [NW-1:0] vld_line;
  side_t         side_line [NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_line <= '0;
    end else begin
      vld_line <= {vld_line[NW-2:0], vld4};
    end
  end

  always_ff @(posedge clk) begin
    side_line[0] <= side4;
    for (int k = 1; k < NW; k++) begin
      side_line[k] <= side_line[k-1];
    end
  end

  // ---------------- stage 5: restore quotient sign ----------------
  logic                 vld5;
  side_t                side5;
  logic signed [NW:0]   s5_qx, s5_qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld_line[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    side5 <= side_line[NW-1];
    s5_qx <= side_line[NW-1].neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    s5_qy <= side_line[NW-1].neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
  end

  // ---------------- stage 6: add centre, saturate, output ----------------
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 fit_x, fit_y;
  logic signed [23:0]   sat_x, sat_y;

  always_comb begin
    sum_x = SW'(s5_qx) + SW'(center_x);
    sum_y = SW'(s5_qy) + SW'(center_y);
    fit_x = (&sum_x[SW-1:23]) || !(|sum_x[SW-1:23]);
    fit_y = (&sum_y[SW-1:23]) || !(|sum_y[SW-1:23]);
    sat_x = fit_x ? sum_x[23:0] : (sum_x[SW-1] ? COP_MIN : COP_MAX);
    sat_y = fit_y ? sum_y[23:0] : (sum_y[SW-1] ? COP_MIN : COP_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    cop_valid <= side5.ok;
    // Drop the quotient where fz is not above the threshold
    cop_x     <= side5.ok ? sat_x : '0;
    cop_y     <= side5.ok ? sat_y : '0;
    force_x   <= side5.f.fx;
    force_y   <= side5.f.fy;
    force_z   <= side5.f.fz;
    moment_x  <= side5.f.mx;
    moment_y  <= side5.f.my;
    moment_z  <= side5.f.mz;
  end

  // ---------------- assertions ----------------
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("transfer did not complete after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted sample");

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    done && !cop_valid |-> cop_x == '0 && cop_y == '0)
    else $error("centre of pressure not cleared when invalid");

  a_valid_strobe : assert property (@(posedge clk) disable iff (rst)
    vld_line[NW-1] |=> vld5 && (side5.ok == $past(side_line[NW-1].ok)))
    else $error("sideband lost alignment with the divider");

endmodule
